// File: src/pdd_pkg.sv
// Shared types, constants and fixed-point helpers for the pixel depth deprojection block.
// Used by pdd_cfg_if and the top level; depends on nothing else.
`default_nettype none

package pdd_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;
  localparam int STAGES     = 11;
  localparam int Z_W        = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRINCIPAL_POINT   = 8'd0,
    REG_INV_FOCAL_X       = 8'd1,
    REG_INV_FOCAL_Y       = 8'd2,
    REG_RADIAL_K1         = 8'd3,
    REG_RADIAL_K2         = 8'd4,
    REG_RADIAL_K3         = 8'd5,
    REG_TANGENTIAL_PAIR   = 8'd6,
    REG_DISTORTION_ENABLE = 8'd7
  } cfg_reg_e;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
  localparam logic signed [63:0] Q_ONE   = 64'sd268435456;
  localparam logic signed [63:0] RND28   = 64'sd134217728;
  localparam logic signed [63:0] RND20   = 64'sd524288;

  // A Q4.28 value together with its clip flag.
  typedef struct packed {
    logic [31:0] v;
    logic        s;
  } qval_t;

  function automatic qval_t clip32(input logic signed [63:0] a);
    qval_t r;
    r.v = a[31:0];
    r.s = 1'b0;
    if (a > S32_MAX) begin
      r.v = S32_MAX[31:0];
      r.s = 1'b1;
    end else if (a < S32_MIN) begin
      r.v = S32_MIN[31:0];
      r.s = 1'b1;
    end
    return r;
  endfunction

  // Q4.28 product, rounded to nearest with halves going up, then clipped.
  function automatic qval_t qmul(input logic signed [31:0] a, input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = p + RND28;
    return clip32(p >>> 28);
  endfunction

endpackage

`default_nettype wire

// File: src/pdd_pix_if.sv
// Input channel carrying one pixel word: column, row and depth.
// Depends on nothing else.
`default_nettype none

interface pdd_pix_if #(
  parameter int PIXEL_BITS = 12,
  parameter int DEPTH_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_x;
  logic [PIXEL_BITS-1:0] pixel_y;
  logic [DEPTH_BITS-1:0] depth_mm;

  modport source (output valid, pixel_x, pixel_y, depth_mm, input ready);
  modport sink (input valid, pixel_x, pixel_y, depth_mm, output ready);
endinterface

`default_nettype wire

// File: src/pdd_pt_if.sv
// Output channel carrying one camera-space point word with its saturation flag.
// Depends on nothing else.
`default_nettype none

interface pdd_pt_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [15:0] point_z;
  logic        saturated;

  modport source (output valid, point_x, point_y, point_z, saturated, input ready);
  modport sink (input valid, point_x, point_y, point_z, saturated, output ready);
endinterface

`default_nettype wire

// File: src/pdd_cfg_if.sv
// Register write channel: register index and write data.
// Depends on pdd_pkg for the field widths.
`default_nettype none

interface pdd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pdd_pkg::CFG_IDX_W-1:0]  index;
  logic [pdd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/pixel_depth_deprojection.sv
// Pixel depth deprojection: pinhole model with optional inverse Brown-Conrady correction.
// An accepted pixel word enters the first stage and leaves the last one as its point word.
// One word per cycle unless the output stalls; the chain r2, r4, r6, f, x*f sets the stage count.
// Each stage holds its word while the next cannot take it, so bubbles close up under a stall.
// Reset clears all valid bits and the configuration registers; data registers are not reset.
// Depends on pdd_pkg, pdd_pix_if, pdd_pt_if and pdd_cfg_if.
`default_nettype none

module pixel_depth_deprojection #(
  parameter int PIXEL_BITS = 12,
  parameter int DEPTH_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  pdd_cfg_if.sink     cfg_i,
  pdd_pix_if.sink     pix_i,
  pdd_pt_if.source    pt_o
);

  localparam int NS  = pdd_pkg::STAGES;
  localparam int ZW  = pdd_pkg::Z_W;
  localparam int PW4 = PIXEL_BITS + 4;
  localparam int DW  = ((PW4 > 16) ? PW4 : 16) + 1;

  // Configuration registers.
  logic [31:0]        pp_q;
  logic [23:0]        ifx_q, ify_q;
  logic signed [31:0] k1_q, k2_q, k3_q, p1_q, p2_q;
  logic               en_q;

  // Pipeline control.
  logic [NS-1:0] vld_q;
  logic [NS-1:0] adv;

  // Payload carried along the pipe.
  logic [DEPTH_BITS-1:0] dep_q [NS];
  logic                  sat_q [NS];
  logic                  sat_d [NS];
  logic signed [DW-1:0]  dx_q, dy_q;
  logic signed [31:0]    x_q [1:8];
  logic signed [31:0]    y_q [1:8];
  logic signed [31:0]    xx_q [2:3];
  logic signed [31:0]    yy_q [2:3];
  logic signed [31:0]    xy_q;
  logic signed [31:0]    r2_q [3:4];
  logic signed [31:0]    p1xy_q [3:8];
  logic signed [31:0]    p2xy_q [3:8];
  logic signed [31:0]    r4_q;
  logic signed [31:0]    k1r2_q [4:6];
  logic signed [31:0]    tx_q, ty_q;
  logic signed [31:0]    r6_q;
  logic signed [31:0]    k2r4_q [5:6];
  logic signed [31:0]    p2tx_q [5:8];
  logic signed [31:0]    p1ty_q [5:8];
  logic signed [31:0]    k3r6_q;
  logic signed [31:0]    f_q;
  logic signed [31:0]    xf_q, yf_q;
  logic signed [31:0]    cx_q, cy_q;
  logic signed [31:0]    ox_q, oy_q;

  // Combinational results of each stage.
  logic signed [DW-1:0] dx_d, dy_d;
  pdd_pkg::qval_t q_x, q_y, q_xx, q_yy, q_xy, q_r2, q_p1xy, q_p2xy;
  pdd_pkg::qval_t q_r4, q_k1r2, q_tx, q_ty, q_r6, q_k2r4, q_p2tx, q_p1ty;
  pdd_pkg::qval_t q_k3r6, q_f, q_xf, q_yf, q_ux, q_uy, q_ox, q_oy;
  logic signed [63:0] prod_x, prod_y, prod_ox, prod_oy;

  // Register writes.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q  <= '0;
      ifx_q <= '0;
      ify_q <= '0;
      k1_q  <= '0;
      k2_q  <= '0;
      k3_q  <= '0;
      p1_q  <= '0;
      p2_q  <= '0;
      en_q  <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        pdd_pkg::REG_PRINCIPAL_POINT:   pp_q  <= cfg_i.data[31:0];
        pdd_pkg::REG_INV_FOCAL_X:       ifx_q <= cfg_i.data[23:0];
        pdd_pkg::REG_INV_FOCAL_Y:       ify_q <= cfg_i.data[23:0];
        pdd_pkg::REG_RADIAL_K1:         k1_q  <= $signed(cfg_i.data[31:0]);
        pdd_pkg::REG_RADIAL_K2:         k2_q  <= $signed(cfg_i.data[31:0]);
        pdd_pkg::REG_RADIAL_K3:         k3_q  <= $signed(cfg_i.data[31:0]);
        pdd_pkg::REG_TANGENTIAL_PAIR: begin
          p1_q <= $signed(cfg_i.data[63:32]);
          p2_q <= $signed(cfg_i.data[31:0]);
        end
        pdd_pkg::REG_DISTORTION_ENABLE: en_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or when its word moves on.
  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || pt_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign pix_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= pix_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_comb begin
    // Offset from the principal point in Q.4 pixels.
    dx_d = $signed(DW'({pix_i.pixel_x, 4'b0000})) - $signed(DW'(pp_q[31:16]));
    dy_d = $signed(DW'({pix_i.pixel_y, 4'b0000})) - $signed(DW'(pp_q[15:0]));
    sat_d[0] = 1'b0;

    // Normalized coordinates.
    prod_x = 64'(dx_q) * 64'($signed({1'b0, ifx_q}));
    prod_y = 64'(dy_q) * 64'($signed({1'b0, ify_q}));
    q_x = pdd_pkg::clip32(prod_x);
    q_y = pdd_pkg::clip32(prod_y);
    sat_d[1] = sat_q[0] | q_x.s | q_y.s;

    q_xx = pdd_pkg::qmul(x_q[1], x_q[1]);
    q_yy = pdd_pkg::qmul(y_q[1], y_q[1]);
    q_xy = pdd_pkg::qmul(x_q[1], y_q[1]);
    sat_d[2] = sat_q[1] | (en_q & (q_xx.s | q_yy.s | q_xy.s));

    q_r2   = pdd_pkg::clip32(64'(xx_q[2]) + 64'(yy_q[2]));
    q_p1xy = pdd_pkg::qmul(p1_q, xy_q);
    q_p2xy = pdd_pkg::qmul(p2_q, xy_q);
    sat_d[3] = sat_q[2] | (en_q & (q_r2.s | q_p1xy.s | q_p2xy.s));

    q_r4   = pdd_pkg::qmul(r2_q[3], r2_q[3]);
    q_k1r2 = pdd_pkg::qmul(k1_q, r2_q[3]);
    q_tx   = pdd_pkg::clip32(64'(r2_q[3]) + (64'(xx_q[3]) <<< 1));
    q_ty   = pdd_pkg::clip32(64'(r2_q[3]) + (64'(yy_q[3]) <<< 1));
    sat_d[4] = sat_q[3] | (en_q & (q_r4.s | q_k1r2.s | q_tx.s | q_ty.s));

    q_r6   = pdd_pkg::qmul(r4_q, r2_q[4]);
    q_k2r4 = pdd_pkg::qmul(k2_q, r4_q);
    q_p2tx = pdd_pkg::qmul(p2_q, tx_q);
    q_p1ty = pdd_pkg::qmul(p1_q, ty_q);
    sat_d[5] = sat_q[4] | (en_q & (q_r6.s | q_k2r4.s | q_p2tx.s | q_p1ty.s));

    q_k3r6 = pdd_pkg::qmul(k3_q, r6_q);
    sat_d[6] = sat_q[5] | (en_q & q_k3r6.s);

    // Radial gain.
    q_f = pdd_pkg::clip32(pdd_pkg::Q_ONE + 64'(k1r2_q[6]) + 64'(k2r4_q[6]) + 64'(k3r6_q));
    sat_d[7] = sat_q[6] | (en_q & q_f.s);

    q_xf = pdd_pkg::qmul(x_q[7], f_q);
    q_yf = pdd_pkg::qmul(y_q[7], f_q);
    sat_d[8] = sat_q[7] | (en_q & (q_xf.s | q_yf.s));

    // Corrected coordinates, or the plain ones when the correction is off.
    q_ux = pdd_pkg::clip32(64'(xf_q) + (64'(p1xy_q[8]) <<< 1) + 64'(p2tx_q[8]));
    q_uy = pdd_pkg::clip32(64'(yf_q) + (64'(p2xy_q[8]) <<< 1) + 64'(p1ty_q[8]));
    sat_d[9] = sat_q[8] | (en_q & (q_ux.s | q_uy.s));

    // Scale by depth and keep 8 fraction bits.
    prod_ox = 64'($signed({1'b0, dep_q[9]})) * 64'(cx_q) + pdd_pkg::RND20;
    prod_oy = 64'($signed({1'b0, dep_q[9]})) * 64'(cy_q) + pdd_pkg::RND20;
    q_ox = pdd_pkg::clip32(prod_ox >>> 20);
    q_oy = pdd_pkg::clip32(prod_oy >>> 20);
    sat_d[10] = sat_q[9] | q_ox.s | q_oy.s;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dep_q[0] <= pix_i.depth_mm;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
    end
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) begin
        dep_q[k] <= dep_q[k-1];
      end
    end
    for (int k = 0; k < NS; k++) begin
      if (adv[k]) begin
        sat_q[k] <= sat_d[k];
      end
    end
    if (adv[1]) begin
      x_q[1] <= $signed(q_x.v);
      y_q[1] <= $signed(q_y.v);
    end
    for (int k = 2; k <= 8; k++) begin
      if (adv[k]) begin
        x_q[k] <= x_q[k-1];
        y_q[k] <= y_q[k-1];
      end
    end
    if (adv[2]) begin
      xx_q[2] <= $signed(q_xx.v);
      yy_q[2] <= $signed(q_yy.v);
      xy_q    <= $signed(q_xy.v);
    end
    if (adv[3]) begin
      xx_q[3]   <= xx_q[2];
      yy_q[3]   <= yy_q[2];
      r2_q[3]   <= $signed(q_r2.v);
      p1xy_q[3] <= $signed(q_p1xy.v);
      p2xy_q[3] <= $signed(q_p2xy.v);
    end
    for (int k = 4; k <= 8; k++) begin
      if (adv[k]) begin
        p1xy_q[k] <= p1xy_q[k-1];
        p2xy_q[k] <= p2xy_q[k-1];
      end
    end
    if (adv[4]) begin
      r2_q[4]   <= r2_q[3];
      r4_q      <= $signed(q_r4.v);
      k1r2_q[4] <= $signed(q_k1r2.v);
      tx_q      <= $signed(q_tx.v);
      ty_q      <= $signed(q_ty.v);
    end
    if (adv[5]) begin
      r6_q      <= $signed(q_r6.v);
      k1r2_q[5] <= k1r2_q[4];
      k2r4_q[5] <= $signed(q_k2r4.v);
      p2tx_q[5] <= $signed(q_p2tx.v);
      p1ty_q[5] <= $signed(q_p1ty.v);
    end
    if (adv[6]) begin
      k3r6_q    <= $signed(q_k3r6.v);
      k1r2_q[6] <= k1r2_q[5];
      k2r4_q[6] <= k2r4_q[5];
    end
    for (int k = 6; k <= 8; k++) begin
      if (adv[k]) begin
        p2tx_q[k] <= p2tx_q[k-1];
        p1ty_q[k] <= p1ty_q[k-1];
      end
    end
    if (adv[7]) begin
      f_q <= $signed(q_f.v);
    end
    if (adv[8]) begin
      xf_q <= $signed(q_xf.v);
      yf_q <= $signed(q_yf.v);
    end
    if (adv[9]) begin
      cx_q <= en_q ? $signed(q_ux.v) : x_q[8];
      cy_q <= en_q ? $signed(q_uy.v) : y_q[8];
    end
    if (adv[10]) begin
      ox_q <= $signed(q_ox.v);
      oy_q <= $signed(q_oy.v);
    end
  end

  assign pt_o.valid     = vld_q[NS-1];
  assign pt_o.point_x   = ox_q;
  assign pt_o.point_y   = oy_q;
  assign pt_o.point_z   = ZW'(dep_q[NS-1]);
  assign pt_o.saturated = sat_q[NS-1];

  // An accepted pixel word always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> vld_q[0])
    else $error("accepted pixel word not captured");

  // A stalled output word is neither dropped nor changed in its x and y.
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS-1] && !pt_o.ready |=> vld_q[NS-1] && $stable(ox_q) && $stable(oy_q))
    else $error("stalled output word lost or changed");

  // A word in stage 4 that cannot move on stays in place.
  a_mid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] && !adv[5] |=> vld_q[4])
    else $error("stalled pipeline word lost");

  // Zero depth always projects to the origin.
  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_o.valid && (dep_q[NS-1] == '0) |-> (ox_q == '0) && (oy_q == '0))
    else $error("zero depth gave a nonzero point");

endmodule

`default_nettype wire
